// ----- hdl/pawg_pkg.sv -----
// Package with the waveform codes, register indexes and reset constants of the waveform generator.
package pawg_pkg;

   typedef enum logic [1:0] {
      WAVE_TRIANGLE = 2'd0,
      WAVE_SAW      = 2'd1,
      WAVE_SQUARE   = 2'd2,
      WAVE_NOISE    = 2'd3
   } wave_type;

   typedef enum logic [1:0] {
      CSR_WAVE_SELECT     = 2'd0,
      CSR_PHASE_INCREMENT = 2'd1,
      CSR_AMPLITUDE       = 2'd2,
      CSR_DUTY_PERCENT    = 2'd3
   } csr_index_type;

   localparam logic [31:0]        NOISE_SEED      = 32'hA3C5_D17F;
   localparam logic signed [15:0] Q15_MAX         = 16'sd32767;
   localparam logic signed [15:0] Q15_NEG_MAX     = -16'sd32767;
   localparam logic signed [15:0] AMPLITUDE_RESET = 16'sd32767;
   localparam logic [6:0]         DUTY_MAX        = 7'd100;
   // Threshold of the reset duty of 50 percent: 50 * 65535 / 100.
   localparam logic [15:0]        THRESH_RESET    = 16'd32767;
   // Reciprocal of 100 scaled by 2^30, rounded up; exact for dividends below 2^23.
   localparam logic [23:0]        DUTY_RECIP      = 24'd10737419;
   localparam int                 DUTY_SHIFT      = 30;

endpackage

// ----- hdl/phase_accumulator_waveform_generator.sv -----
// Top level of the phase accumulator waveform generator with output register and skid stage.
//
//   channel | ports                                              | direction
//   --------+----------------------------------------------------+----------
//   req     | req_valid req_stall req_load_phase req_phase_value  | in
//           | req_block_end                                      |
//   rsp     | rsp_valid rsp_stall rsp_sample rsp_block_end_out   | out
//   csr     | csr_write_enable csr_index csr_write_data          | in
//
// One beat is accepted per cycle while req_stall is low; its sample is registered in the output
// register, or in the skid register while the output is held. The waveform select, gain multiply
// and saturation sit between the state registers and the output register as a single stage.
// Reset is synchronous and restores the register defaults, phase zero and the noise seed.
// A stalled result stays in the output register while the skid register takes one more beat;
// req_stall is high only while the skid register is full.
module phase_accumulator_waveform_generator
   import pawg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_load_phase,
   input  logic [31:0]        req_phase_value,
   input  logic               req_block_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_block_end_out,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   // Configuration registers.
   wave_type           wave_ff;
   logic [31:0]        inc_ff;
   logic signed [15:0] amp_ff;
   logic [15:0]        thresh_ff;
   logic [15:0]        thresh_in;

   // Generator state.
   logic [31:0] phase_ff, phase_in;
   logic [31:0] noise_ff, noise_in;

   // Output register and skid register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_end_ff, rsp_end_in;
   logic               skid_valid_ff, skid_valid_in;
   logic signed [15:0] skid_sample_ff, skid_sample_in;
   logic               skid_end_ff, skid_end_in;

   logic               accept;
   logic               move;
   logic [31:0]        phase_cur;
   logic [15:0]        x;
   logic [31:0]        nz1, nz2, nz3;
   logic signed [17:0] tri_wide;
   logic signed [15:0] raw;
   logic signed [31:0] prod;
   logic signed [16:0] scaled;
   logic signed [15:0] sample_new;

   logic [6:0]  duty_clamped;
   logic [22:0] duty_scaled;
   logic [46:0] duty_prod;

   assign accept = req_valid && !req_stall;
   assign move   = rsp_valid_ff && !rsp_stall;

   // Duty threshold on the upper 16 phase bits, worked out once when the register is written.
   always_comb begin
      duty_clamped = (csr_write_data[6:0] > DUTY_MAX) ? DUTY_MAX : csr_write_data[6:0];
      duty_scaled  = {duty_clamped, 16'd0} - {16'd0, duty_clamped};
      duty_prod    = {24'd0, duty_scaled} * {23'd0, DUTY_RECIP};
      thresh_in    = duty_prod[DUTY_SHIFT +: 16];
   end

   always_comb begin
      phase_cur = req_load_phase ? req_phase_value : phase_ff;
      x         = phase_cur[31:16];

      nz1 = noise_ff ^ (noise_ff << 13);
      nz2 = nz1 ^ (nz1 >> 17);
      nz3 = nz2 ^ (nz2 << 5);

      // Rising half is 2x - 32767, falling half is 98303 - 2x.
      if (!x[15]) begin
         tri_wide = $signed({1'b0, x, 1'b0}) - 18'sd32767;
      end else begin
         tri_wide = 18'sd98303 - $signed({1'b0, x, 1'b0});
      end

      unique case (wave_ff)
         WAVE_TRIANGLE: raw = tri_wide[15:0];
         WAVE_SAW:      raw = $signed({~x[15], x[14:0]});
         WAVE_SQUARE:   raw = (x < thresh_ff) ? Q15_MAX : Q15_NEG_MAX;
         WAVE_NOISE:    raw = $signed(nz3[15:0]);
         default:       raw = Q15_MAX;
      endcase

      // Floor shift of the Q15 product; only -32768 times -32768 overflows.
      prod   = 32'(raw) * 32'(amp_ff);
      scaled = prod[31:15];
      if (scaled > 17'sd32767) begin
         sample_new = Q15_MAX;
      end else begin
         sample_new = scaled[15:0];
      end

      if (wave_ff == WAVE_NOISE) begin
         phase_in = phase_cur;
         noise_in = nz3;
      end else begin
         phase_in = phase_cur + inc_ff;
         noise_in = noise_ff;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_end_in     = rsp_end_ff;
      skid_valid_in  = skid_valid_ff;
      skid_sample_in = skid_sample_ff;
      skid_end_in    = skid_end_ff;
      if (!rsp_valid_ff || move) begin
         if (skid_valid_ff) begin
            // No beat is accepted while the skid register is full.
            rsp_valid_in  = 1'b1;
            rsp_sample_in = skid_sample_ff;
            rsp_end_in    = skid_end_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = accept;
            rsp_sample_in = sample_new;
            rsp_end_in    = req_block_end;
         end
      end else if (accept) begin
         skid_valid_in  = 1'b1;
         skid_sample_in = sample_new;
         skid_end_in    = req_block_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff       <= WAVE_TRIANGLE;
         inc_ff        <= '0;
         amp_ff        <= AMPLITUDE_RESET;
         thresh_ff     <= THRESH_RESET;
         phase_ff      <= '0;
         noise_ff      <= NOISE_SEED;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_WAVE_SELECT:     wave_ff   <= wave_type'(csr_write_data[1:0]);
               CSR_PHASE_INCREMENT: inc_ff    <= csr_write_data;
               CSR_AMPLITUDE:       amp_ff    <= $signed(csr_write_data[15:0]);
               CSR_DUTY_PERCENT:    thresh_ff <= thresh_in;
               default:             wave_ff   <= wave_ff;
            endcase
         end
         if (accept) begin
            phase_ff <= phase_in;
            noise_ff <= noise_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff  <= rsp_sample_in;
      rsp_end_ff     <= rsp_end_in;
      skid_sample_ff <= skid_sample_in;
      skid_end_ff    <= skid_end_in;
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = rsp_sample_ff;
   assign rsp_block_end_out = rsp_end_ff;

   // The skid register only fills behind a result that is held.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // Noise beats without a load leave the phase where it was.
   a_noise_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      (accept && wave_ff == WAVE_NOISE && !req_load_phase) |=> $stable(phase_ff))
      else $error("phase moved on a noise beat");

   // Phase-based beats leave the noise generator alone.
   a_phase_keeps_noise: assert property (@(posedge clock) disable iff (reset)
      (accept && wave_ff != WAVE_NOISE) |=> $stable(noise_ff))
      else $error("noise register moved on a phase-based beat");

   // The xorshift generator never reaches the all-zero state.
   a_noise_nonzero: assert property (@(posedge clock) disable iff (reset)
      noise_ff != 32'd0)
      else $error("noise register is zero");

   // Floor scaling with saturation can never produce the most negative code.
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sample_ff != -16'sd32768)
      else $error("sample outside the scaled range");

endmodule
